@@ sv/sbi_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment box intersection package
// Shared constants: default coordinate width, register indices and counts.
// ----------------------------------------------------------------------------
package sbi_pkg;

	// Default coordinate width in bits (signed fixed point).
	localparam int COORD_WIDTH = 32;

	// Register index port width and register indices.
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;

	// Geometry counts.
	localparam int NUM_AXES  = 3;
	localparam int NUM_FACES = 6;

endpackage

@@ sv/segment_box_intersection.sv @@
// ----------------------------------------------------------------------------
// Segment box intersection
// Streams 3D segments against a configured axis-aligned box and reports the
// first face crossing point in face order, or the start point when it lies strictly inside the box.
// ----------------------------------------------------------------------------
// A new segment may be started in every clock cycle; busy is always low. Each
// result appears on the result ports with done high for exactly one cycle.
// The face dividers resolve one quotient bit per pipeline stage. Results come
// out in start order and cannot be held off. Box registers must only be written
// while no transaction is in flight. On a miss the hit flag and all point
// coordinates are zero.
module segment_box_intersection #(
	parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [sbi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_addr,
	input  logic [COORD_WIDTH-1:0]                cfg_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_WIDTH-1:0]         start_x,
	input  logic signed [COORD_WIDTH-1:0]         start_y,
	input  logic signed [COORD_WIDTH-1:0]         start_z,
	input  logic signed [COORD_WIDTH-1:0]         end_x,
	input  logic signed [COORD_WIDTH-1:0]         end_y,
	input  logic signed [COORD_WIDTH-1:0]         end_z,
	output logic                                  done,
	output logic                                  hit,
	output logic signed [COORD_WIDTH-1:0]         hit_x,
	output logic signed [COORD_WIDTH-1:0]         hit_y,
	output logic signed [COORD_WIDTH-1:0]         hit_z
);

	localparam int W       = COORD_WIDTH;
	localparam int NA      = sbi_pkg::NUM_AXES;
	localparam int NF      = sbi_pkg::NUM_FACES;
	localparam int DIV_LAT = W + 1;

	// Box registers, one per axis for each corner.
	logic signed [W-1:0] box_lo_q [NA];
	logic signed [W-1:0] box_hi_q [NA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NA; c++) begin
				box_lo_q[c] <= '0;
				box_hi_q[c] <= '0;
			end
		end else if (cfg_write) begin
			unique case (cfg_addr)
				sbi_pkg::REG_BOX_MIN_X: box_lo_q[0] <= cfg_wdata;
				sbi_pkg::REG_BOX_MIN_Y: box_lo_q[1] <= cfg_wdata;
				sbi_pkg::REG_BOX_MIN_Z: box_lo_q[2] <= cfg_wdata;
				sbi_pkg::REG_BOX_MAX_X: box_hi_q[0] <= cfg_wdata;
				sbi_pkg::REG_BOX_MAX_Y: box_hi_q[1] <= cfg_wdata;
				sbi_pkg::REG_BOX_MAX_Z: box_hi_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic signed [W-1:0] s_in [NA];
	logic signed [W-1:0] e_in [NA];
	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign e_in[0] = end_x;
	assign e_in[1] = end_y;
	assign e_in[2] = end_z;

	// Stage 1: direction, plane distances, crossing flags and early decisions.
	logic                neg_c   [NA];
	logic [W-1:0]        mag_c   [NA];
	logic [W-1:0]        num_c   [NF];
	logic                cross_c [NF];
	logic                reject_c;
	logic                inside_c;

	always_comb begin
		logic signed [W:0] dlt;
		logic signed [W:0] bnd;
		logic signed [W:0] d1;
		logic signed [W:0] d2;
		reject_c = 1'b0;
		inside_c = 1'b1;
		for (int c = 0; c < NA; c++) begin
			dlt = (W+1)'(e_in[c]) - (W+1)'(s_in[c]);
			neg_c[c] = dlt < 0;
			mag_c[c] = dlt < 0 ? W'(-dlt) : W'(dlt);
			if ((s_in[c] < box_lo_q[c] && e_in[c] < box_lo_q[c]) ||
			    (s_in[c] > box_hi_q[c] && e_in[c] > box_hi_q[c])) begin
				reject_c = 1'b1;
			end
			if (!(s_in[c] > box_lo_q[c] && s_in[c] < box_hi_q[c])) begin
				inside_c = 1'b0;
			end
		end
		for (int f = 0; f < NF; f++) begin
			bnd = (f < NA) ? (W+1)'(box_lo_q[f % NA]) : (W+1)'(box_hi_q[f % NA]);
			d1 = (W+1)'(s_in[f % NA]) - bnd;
			d2 = (W+1)'(e_in[f % NA]) - bnd;
			cross_c[f] = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
			num_c[f]   = d1 < 0 ? W'(-d1) : W'(d1);
		end
	end

	logic                v_s1;
	logic signed [W-1:0] s_s1     [NA];
	logic                neg_s1   [NA];
	logic [W-1:0]        mag_s1   [NA];
	logic [W-1:0]        num_s1   [NF];
	logic                cross_s1 [NF];
	logic                reject_s1;
	logic                inside_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		s_s1      <= s_in;
		neg_s1    <= neg_c;
		mag_s1    <= mag_c;
		num_s1    <= num_c;
		cross_s1  <= cross_c;
		reject_s1 <= reject_c;
		inside_s1 <= inside_c;
	end

	// Face dividers: one scaled quotient per face and per off-plane axis.
	logic [W-1:0] quo [NF][NA];

	for (genvar f = 0; f < NF; f++) begin : g_face
		for (genvar c = 0; c < NA; c++) begin : g_axis
			if (c != f % NA) begin : g_div
				sbi_muldiv #(.W(W)) u_muldiv (
					.clk (clk),
					.a   (mag_s1[c]),
					.b   (num_s1[f]),
					.d   (mag_s1[f % NA]),
					.q   (quo[f][c])
				);
			end else begin : g_plane
				// The point lies on the face plane on this axis.
				assign quo[f][c] = '0;
			end
		end
	end

	// Side data delay line, matched to the divider latency.
	logic                v_dl_q      [DIV_LAT];
	logic signed [W-1:0] s_dl_q      [DIV_LAT][NA];
	logic                neg_dl_q    [DIV_LAT][NA];
	logic                cross_dl_q  [DIV_LAT][NF];
	logic                reject_dl_q [DIV_LAT];
	logic                inside_dl_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				v_dl_q[k] <= 1'b0;
			end
		end else begin
			v_dl_q[0] <= v_s1;
			for (int k = 1; k < DIV_LAT; k++) begin
				v_dl_q[k] <= v_dl_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		s_dl_q[0]      <= s_s1;
		neg_dl_q[0]    <= neg_s1;
		cross_dl_q[0]  <= cross_s1;
		reject_dl_q[0] <= reject_s1;
		inside_dl_q[0] <= inside_s1;
		for (int k = 1; k < DIV_LAT; k++) begin
			s_dl_q[k]      <= s_dl_q[k-1];
			neg_dl_q[k]    <= neg_dl_q[k-1];
			cross_dl_q[k]  <= cross_dl_q[k-1];
			reject_dl_q[k] <= reject_dl_q[k-1];
			inside_dl_q[k] <= inside_dl_q[k-1];
		end
	end

	// Stage 2: crossing points and the strict face rectangle test.
	logic [W-1:0] pt_c   [NF][NA];
	logic         pass_c [NF];

	always_comb begin
		logic signed [W:0] p;
		logic signed [W:0] qx;
		for (int f = 0; f < NF; f++) begin
			pass_c[f] = cross_dl_q[DIV_LAT-1][f];
			for (int c = 0; c < NA; c++) begin
				qx = $signed({1'b0, quo[f][c]});
				if (c == f % NA) begin
					p = (f < NA) ? (W+1)'(box_lo_q[c]) : (W+1)'(box_hi_q[c]);
				end else if (neg_dl_q[DIV_LAT-1][c]) begin
					p = (W+1)'(s_dl_q[DIV_LAT-1][c]) - qx;
				end else begin
					p = (W+1)'(s_dl_q[DIV_LAT-1][c]) + qx;
				end
				if (c != f % NA &&
				    !(p > (W+1)'(box_lo_q[c]) && p < (W+1)'(box_hi_q[c]))) begin
					pass_c[f] = 1'b0;
				end
				pt_c[f][c] = p[W-1:0];
			end
		end
	end

	logic                v_s2;
	logic [W-1:0]        pt_s2     [NF][NA];
	logic                pass_s2   [NF];
	logic signed [W-1:0] s_s2      [NA];
	logic                reject_s2;
	logic                inside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_dl_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		pt_s2     <= pt_c;
		pass_s2   <= pass_c;
		s_s2      <= s_dl_q[DIV_LAT-1];
		reject_s2 <= reject_dl_q[DIV_LAT-1];
		inside_s2 <= inside_dl_q[DIV_LAT-1];
	end

	// Stage 3: pick the result; reject, then inside start, then face order.
	logic         found_c;
	logic [W-1:0] res_c [NA];

	always_comb begin
		found_c = 1'b0;
		for (int c = 0; c < NA; c++) begin
			res_c[c] = '0;
		end
		priority if (reject_s2) begin
			found_c = 1'b0;
		end else if (inside_s2) begin
			found_c = 1'b1;
			for (int c = 0; c < NA; c++) begin
				res_c[c] = s_s2[c];
			end
		end else begin
			for (int f = 0; f < NF; f++) begin
				if (!found_c && pass_s2[f]) begin
					found_c = 1'b1;
					for (int c = 0; c < NA; c++) begin
						res_c[c] = pt_s2[f][c];
					end
				end
			end
		end
	end

	logic                done_s3;
	logic                hit_s3;
	logic signed [W-1:0] hit_x_s3;
	logic signed [W-1:0] hit_y_s3;
	logic signed [W-1:0] hit_z_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
			hit_s3  <= 1'b0;
		end else begin
			done_s3 <= v_s2;
			hit_s3  <= v_s2 && found_c;
		end
	end

	always_ff @(posedge clk) begin
		hit_x_s3 <= res_c[0];
		hit_y_s3 <= res_c[1];
		hit_z_s3 <= res_c[2];
	end

	assign done  = done_s3;
	assign hit   = hit_s3;
	assign hit_x = hit_x_s3;
	assign hit_y = hit_y_s3;
	assign hit_z = hit_z_s3;

	// A hit is only ever flagged on a result transaction.
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> done_s3)
		else $error("Hit flagged without a result transaction.");

	// A miss reports the zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s3 && !hit_s3) |-> (hit_x_s3 == '0 && hit_y_s3 == '0 && hit_z_s3 == '0))
		else $error("Miss reported with a non-zero point.");

	// A reported point never lies outside the box.
	a_hit_x_box: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> (hit_x_s3 >= box_lo_q[0] && hit_x_s3 <= box_hi_q[0]))
		else $error("Reported x lies outside the box.");

	a_hit_y_box: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> (hit_y_s3 >= box_lo_q[1] && hit_y_s3 <= box_hi_q[1]))
		else $error("Reported y lies outside the box.");

	a_hit_z_box: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s3 |-> (hit_z_s3 >= box_lo_q[2] && hit_z_s3 <= box_hi_q[2]))
		else $error("Reported z lies outside the box.");

endmodule

@@ sv/sbi_muldiv.sv @@
// ----------------------------------------------------------------------------
// Pipelined scaled quotient
// Computes floor(a * b / d) for b < d with one registered multiply followed by
// a restoring divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbi_muldiv #(
	parameter int W = sbi_pkg::COORD_WIDTH
) (
	input  logic         clk,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	// Product and divisor register.
	logic [2*W-1:0] prod_s1;
	logic [W-1:0]   den_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= (2*W)'(a) * (2*W)'(b);
		den_s1  <= d;
	end

	// Divider stages. Since b < d, the upper half of the product is below the
	// divisor, so it is the starting remainder and the quotient fits W bits.
	// The lower half shifts out one bit per stage while quotient bits shift in.
	logic [W-1:0] rem_s [1:W];
	logic [W-1:0] low_s [1:W];
	logic [W-1:0] den_s [1:W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0] rem_in;
		logic [W-1:0] low_in;
		logic [W-1:0] den_in;
		logic [W:0]   trial;
		logic         fits;

		if (k == 0) begin : g_first
			assign rem_in = prod_s1[2*W-1:W];
			assign low_in = prod_s1[W-1:0];
			assign den_in = den_s1;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign low_in = low_s[k];
			assign den_in = den_s[k];
		end

		assign trial = {rem_in, low_in[W-1]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
			low_s[k+1] <= {low_in[W-2:0], fits};
			den_s[k+1] <= den_in;
		end
	end

	assign q = low_s[W];

endmodule
